[rtl/sfd_pkg.sv]
package sfd_pkg;

    // frame bytes and limits
    localparam logic [7:0] SYNC_HEAD = 8'h55;
    localparam logic [7:0] SYNC_ZERO = 8'h00;
    localparam logic [7:0] SYNC_TAIL = 8'hAA;
    localparam logic [7:0] MIN_LEN   = 8'd9;
    localparam logic [7:0] HDR_LEN   = 8'd8;
    localparam int         DEF_MAX_PAYLOAD = 64;

    // widths of the fixed fields
    localparam int CNT_W   = 7;
    localparam int INDEX_W = 6;
    localparam int DATA_W  = 32;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_TRAILER  = 2'd2,
        ST_LENGTH   = 2'd3
    } t_status;

    // one finished frame or error, handed from parser to emitter
    typedef struct packed {
        t_status            status;
        logic [7:0]         kind;
        logic [7:0]         addr;
        logic [CNT_W-1:0]   cnt;
        logic               bank;
    } t_cmd;

    // emitter tells the parser a payload bank is free again
    typedef struct packed {
        logic vld;
        logic bank;
    } t_release;

endpackage

[rtl/sfd_ram.sv]
module sfd_ram import sfd_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sfd_front.sv]
module sfd_front import sfd_pkg::*; #(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
    parameter int IW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output t_cmd          o_cmd,
    input  t_release      i_release,
    output logic          o_we,
    output logic [IW:0]   o_waddr,
    output logic [7:0]    o_wdata
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD + 8);

    typedef enum logic [8:0] {
        F_HUNT = 9'b000000001,
        F_SYN0 = 9'b000000010,
        F_LEN  = 9'b000000100,
        F_TYPE = 9'b000001000,
        F_ADDR = 9'b000010000,
        F_DATA = 9'b000100000,
        F_CSUM = 9'b001000000,
        F_TRL0 = 9'b010000000,
        F_TRL1 = 9'b100000000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_kind, n_kind;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_wb;
    logic [1:0]       r_busy, n_busy;
    logic             acc;
    logic             may_push;
    logic [7:0]       cnt_next;

    // stall when a result might not fit the queue, or the fill bank is still in use
    assign may_push = (r_phase == F_LEN) || (r_phase == F_CSUM) ||
                      (r_phase == F_TRL0) || (r_phase == F_TRL1);
    assign o_ready  = !(may_push && i_q_full) && !((r_phase == F_DATA) && r_busy[r_wb]);
    assign acc      = i_valid && o_ready;
    assign cnt_next = 8'(r_cnt) + 8'd1;

    // payload bytes go straight into the current bank
    assign o_we    = acc && (r_phase == F_DATA);
    assign o_waddr = {r_wb, r_cnt[IW-1:0]};
    assign o_wdata = i_byte;

    // parse one byte
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_kind  = r_kind;
        n_addr  = r_addr;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_cmd   = '{status: ST_OK, kind: r_kind, addr: r_addr, cnt: r_cnt, bank: r_wb};
        if (acc) begin
            unique case (r_phase)
                F_SYN0: begin
                    n_phase = (i_byte == SYNC_ZERO) ? F_LEN : F_HUNT;
                end
                F_LEN: begin
                    if (i_byte < MIN_LEN || i_byte > MAX_LEN) begin
                        o_push       = 1'b1;
                        o_cmd.status = ST_LENGTH;
                        o_cmd.kind   = 8'd0;
                        o_cmd.addr   = 8'd0;
                        n_phase      = F_HUNT;
                    end else begin
                        n_len   = i_byte;
                        n_sum   = i_byte;
                        n_phase = F_TYPE;
                    end
                end
                F_TYPE: begin
                    n_kind  = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_phase = F_ADDR;
                end
                F_ADDR: begin
                    n_addr  = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_cnt   = '0;
                    n_phase = F_DATA;
                end
                F_DATA: begin
                    n_sum = r_sum + i_byte;
                    n_cnt = cnt_next[CNT_W-1:0];
                    if (cnt_next == r_len - HDR_LEN) begin
                        n_phase = F_CSUM;
                    end
                end
                F_CSUM: begin
                    if (i_byte == ~r_sum) begin
                        n_phase = F_TRL0;
                    end else begin
                        o_push       = 1'b1;
                        o_cmd.status = ST_CHECKSUM;
                        n_phase      = F_HUNT;
                    end
                end
                F_TRL0: begin
                    if (i_byte == SYNC_ZERO) begin
                        n_phase = F_TRL1;
                    end else begin
                        o_push       = 1'b1;
                        o_cmd.status = ST_TRAILER;
                        n_phase      = F_HUNT;
                    end
                end
                F_TRL1: begin
                    o_push = 1'b1;
                    if (i_byte != SYNC_TAIL) begin
                        o_cmd.status = ST_TRAILER;
                    end
                    n_phase = F_HUNT;
                end
                default: begin
                    n_phase = (i_byte == SYNC_HEAD) ? F_SYN0 : F_HUNT;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= F_HUNT;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_len   <= '0;
            r_kind  <= '0;
            r_addr  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_kind  <= n_kind;
            r_addr  <= n_addr;
        end
    end

    // bank ownership: set when a good frame is queued, freed after its last read
    always_comb begin
        n_busy = r_busy;
        if (i_release.vld) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push && o_cmd.status == ST_OK) begin
            n_busy[r_wb] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb   <= 1'b0;
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
            if (o_push && o_cmd.status == ST_OK) begin
                r_wb <= ~r_wb;
            end
        end
    end

endmodule

[rtl/sfd_cmdq.sv]
module sfd_cmdq import sfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // two-entry queue of frame results
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

endmodule

[rtl/sfd_back.sv]
module sfd_back import sfd_pkg::*; #(
    parameter int IW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_re,
    output logic [IW:0]       o_raddr,
    input  logic [7:0]        i_rdata,
    output t_release          o_release,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic [1:0]        o_user,
    output logic              o_last
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_EMIT = 3'b010,
        B_ERR  = 3'b100
    } t_bstate;

    t_bstate          r_state, n_state;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] idx_next;

    // read stage: data arrives from the ram in the cycle after the read
    logic             r_rd_vld;
    logic [7:0]       r_rd_kind;
    logic [7:0]       r_rd_addr;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_rd_last;

    // output register
    logic             r_ovld;
    t_status          r_ostat;
    logic [7:0]       r_okind;
    logic [7:0]       r_oaddr;
    logic [7:0]       r_obyte;
    logic [INDEX_W-1:0] r_oidx;
    logic             r_olast;

    logic can_load;
    logic issue;
    logic load_rd;
    logic load_err;

    assign can_load = !r_ovld || i_ready;
    assign idx_next = r_idx + 1'b1;
    assign issue    = (r_state == B_EMIT) && (!r_rd_vld || can_load);
    assign load_rd  = r_rd_vld && can_load;
    assign load_err = (r_state == B_ERR) && !r_rd_vld && can_load;
    assign o_pop    = (r_state == B_IDLE) && !i_q_empty;

    assign o_re            = issue;
    assign o_raddr         = {r_cmd.bank, r_idx[IW-1:0]};
    assign o_release.vld   = issue && (idx_next == r_cmd.cnt);
    assign o_release.bank  = r_cmd.bank;

    // sequencer over the queued results
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_state = (i_cmd.status == ST_OK) ? B_EMIT : B_ERR;
                end
            end
            B_EMIT: begin
                if (o_release.vld) begin
                    n_state = B_IDLE;
                end
            end
            B_ERR: begin
                if (load_err) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (can_load) begin
                r_rd_vld <= 1'b0;
            end
            if (load_rd || load_err) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // command, read tags and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= idx_next;
        end
        if (issue) begin
            r_rd_kind <= r_cmd.kind;
            r_rd_addr <= r_cmd.addr;
            r_rd_idx  <= r_idx;
            r_rd_last <= (idx_next == r_cmd.cnt);
        end
        if (load_rd) begin
            r_ostat <= ST_OK;
            r_okind <= r_rd_kind;
            r_oaddr <= r_rd_addr;
            r_obyte <= i_rdata;
            r_oidx  <= r_rd_idx[INDEX_W-1:0];
            r_olast <= r_rd_last;
        end else if (load_err) begin
            r_ostat <= r_cmd.status;
            r_okind <= r_cmd.kind;
            r_oaddr <= r_cmd.addr;
            r_obyte <= 8'd0;
            r_oidx  <= '0;
            r_olast <= 1'b1;
        end
    end

    assign o_valid = r_ovld;
    assign o_user  = r_ostat;
    assign o_last  = r_olast;
    assign o_data  = {2'b00, r_oidx, r_obyte, r_oaddr, r_okind};

endmodule

[rtl/serial_frame_deframer.sv]
// a good frame's items pass the result queue, a ram read and the output register after its
//   closing byte is taken; an error item passes the result queue and the output register
// throughput: one received byte per cycle, payload replayed at one item per cycle from a
//   two-bank store while the output is ready; payload bytes stall while both banks wait for
//   replay, and length, checksum and trailer bytes stall while the queue is full
// reset (i_rst_n low, synchronous) clears parser, queue and emitter; store not cleared
module serial_frame_deframer import sfd_pkg::*; #(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // frame_type, frame_address, payload_byte,
                                              // byte_index, zero pad
    output logic [1:0]        m_axis_tuser,   // status
    output logic              m_axis_tlast
);

    localparam int IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 2 ** (IW + 1);

    logic     push, q_full, pop, q_empty;
    t_cmd     cmd_in, cmd_out;
    t_release release_bank;
    logic     we, re;
    logic [IW:0] waddr, raddr;
    logic [7:0]  wdata, rdata;

    sfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .IW(IW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (cmd_in),
        .i_release (release_bank),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    sfd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (cmd_out)
    );

    sfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sfd_back #(.IW(IW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (cmd_out),
        .o_pop     (pop),
        .o_re      (re),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_release (release_bank),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

[rtl/sfd_checker.sv]
module sfd_checker import sfd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [7:0]        s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser,
    input logic              m_axis_tlast
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // an error item is a run of one with no payload
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |->
        m_axis_tlast && m_axis_tdata[29:16] == 14'd0)
        else $error("error item carries payload or is not last");

    // a length error comes before type and address exist
    a_len_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_LENGTH |-> m_axis_tdata[15:0] == 16'd0)
        else $error("length error carries header fields");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a taken input byte is known
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
        else $error("input item taken with unknown data");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
